// ===== design/tcw_pkg.sv =====
// ============================================================================
// Text console writer package
// Screen geometry, field widths, character codes and the command and status
// bundles shared by the controller and the datapath.
// ============================================================================
package tcw_pkg;

    // Screen geometry.
    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;

    // Field widths fixed by the port definition.
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LIN_W  = 11;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 2 * CHAR_W;

    // Screen store: each physical row occupies a power-of-two stride of columns.
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = SCREEN_HEIGHT * (1 << COL_W);

    // Character codes with a control meaning.
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
    localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'd7;

    // Item kinds.
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the accepted input item
        logic exec;       // perform the put or issue the cell read
        logic clear_all;  // write one cell of the power-up sweep
        logic clear_row;  // write one cell of the scrolled-in bottom row
        logic load_out;   // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scroll;        // the current put item scrolls the screen
        logic clr_col_last;  // clear column counter is at the last column
        logic clr_row_last;  // clear row counter is at the last row
    } t_dp_stat;

    // Physical row that holds a visible row; both inputs are below the height.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] vis);
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, vis};
        if (sum >= (ROW_W+1)'(SCREEN_HEIGHT)) begin
            sum = sum - (ROW_W+1)'(SCREEN_HEIGHT);
        end
        return sum[ROW_W-1:0];
    endfunction

endpackage

// ===== design/tcw_in_if.sv =====
// ============================================================================
// Text console input channel
// Valid/ready channel that carries one put or read item.
// ============================================================================
interface tcw_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [tcw_pkg::CHAR_W-1:0]  char_code;
    logic [tcw_pkg::ROW_W-1:0]   read_row;
    logic [tcw_pkg::COL_W-1:0]   read_col;

    modport source (output valid, output kind, output char_code, output read_row,
                    output read_col, input ready);
    modport sink   (input valid, input kind, input char_code, input read_row,
                    input read_col, output ready);
endinterface

// ===== design/tcw_out_if.sv =====
// ============================================================================
// Text console result channel
// Valid/ready channel that carries the cursor position and the cell read.
// ============================================================================
interface tcw_out_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::COL_W-1:0]   cursor_col;
    logic [tcw_pkg::ROW_W-1:0]   cursor_row;
    logic [tcw_pkg::LIN_W-1:0]   cursor_linear;
    logic [tcw_pkg::CHAR_W-1:0]  cell_char;
    logic [tcw_pkg::CHAR_W-1:0]  cell_attr;

    modport source (output valid, output cursor_col, output cursor_row,
                    output cursor_linear, output cell_char, output cell_attr,
                    input ready);
    modport sink   (input valid, input cursor_col, input cursor_row,
                    input cursor_linear, input cell_char, input cell_attr,
                    output ready);
endinterface

// ===== design/tcw_datapath.sv =====
// ============================================================================
// Text console datapath
// Cursor and scroll registers, the screen store, the clear counters and the
// result register, all driven by commands from the controller.
// ============================================================================
module tcw_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tcw_pkg::t_dp_cmd            i_cmd,
    output tcw_pkg::t_dp_stat           o_stat,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_cfg_data,
    input  logic                        i_kind,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]   i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]   i_read_col,
    output logic [tcw_pkg::COL_W-1:0]   o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]   o_cursor_row,
    output logic [tcw_pkg::LIN_W-1:0]   o_cursor_linear,
    output logic [tcw_pkg::CHAR_W-1:0]  o_cell_char,
    output logic [tcw_pkg::CHAR_W-1:0]  o_cell_attr
);

    localparam logic [tcw_pkg::COL_W-1:0] COL_LAST = tcw_pkg::COL_W'(tcw_pkg::SCREEN_WIDTH - 1);
    localparam logic [tcw_pkg::ROW_W-1:0] ROW_LAST = tcw_pkg::ROW_W'(tcw_pkg::SCREEN_HEIGHT - 1);

    // Cursor, scroll offset and attribute.
    logic [tcw_pkg::COL_W-1:0]  r_col, n_col;
    logic [tcw_pkg::ROW_W-1:0]  r_row, n_row;
    logic [tcw_pkg::ROW_W-1:0]  r_top, n_top;
    logic [tcw_pkg::CHAR_W-1:0] r_attr;

    // Clear sweep counters (physical row, column).
    logic [tcw_pkg::ROW_W-1:0]  r_clr_row, n_clr_row;
    logic [tcw_pkg::COL_W-1:0]  r_clr_col, n_clr_col;

    // Captured input item.
    logic                       r_kind;
    logic [tcw_pkg::CHAR_W-1:0] r_char;
    logic [tcw_pkg::ROW_W-1:0]  r_read_row;
    logic [tcw_pkg::COL_W-1:0]  r_read_col;

    // Screen store and its ports.
    logic [tcw_pkg::CELL_W-1:0] r_mem [tcw_pkg::MEM_DEPTH];
    logic [tcw_pkg::CELL_W-1:0] r_rd_data;
    logic                       w_we;
    logic [tcw_pkg::ADDR_W-1:0] w_waddr;
    logic [tcw_pkg::CELL_W-1:0] w_wdata;
    logic [tcw_pkg::ADDR_W-1:0] w_raddr;

    // Result register.
    logic [tcw_pkg::COL_W-1:0]  r_o_col;
    logic [tcw_pkg::ROW_W-1:0]  r_o_row;
    logic [tcw_pkg::LIN_W-1:0]  r_o_lin;
    logic [tcw_pkg::CHAR_W-1:0] r_o_char;
    logic [tcw_pkg::CHAR_W-1:0] r_o_attr;

    logic w_printable;
    logic w_col_end;
    logic w_row_end;
    logic w_new_line;
    logic w_scroll;
    logic w_in_range;
    logic [tcw_pkg::ROW_W-1:0]  w_read_prow;
    logic [tcw_pkg::LIN_W-1:0]  w_linear;

    // Decode of the captured item.
    assign w_printable = (r_char != tcw_pkg::CH_NEWLINE) && (r_char != tcw_pkg::CH_RETURN) &&
                         (r_char != tcw_pkg::CH_BACKSPACE);
    assign w_col_end   = (r_col == COL_LAST);
    assign w_row_end   = (r_row == ROW_LAST);
    assign w_scroll    = (r_kind == tcw_pkg::KIND_PUT) && w_row_end &&
                         ((r_char == tcw_pkg::CH_NEWLINE) || (w_printable && w_col_end));
    assign w_in_range  = (r_read_row < tcw_pkg::ROW_W'(tcw_pkg::SCREEN_HEIGHT)) &&
                         (r_read_col < tcw_pkg::COL_W'(tcw_pkg::SCREEN_WIDTH));
    assign w_read_prow = w_in_range ? tcw_pkg::phys_row(r_top, r_read_row) : '0;
    assign w_raddr     = {w_read_prow, r_read_col};
    assign w_linear    = tcw_pkg::LIN_W'(r_row) * tcw_pkg::LIN_W'(tcw_pkg::SCREEN_WIDTH) +
                         tcw_pkg::LIN_W'(r_col);

    assign o_stat.scroll       = w_scroll;
    assign o_stat.clr_col_last = (r_clr_col == COL_LAST);
    assign o_stat.clr_row_last = (r_clr_row == ROW_LAST);

    // Next cursor state and the single store write of this cycle.
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_top      = r_top;
        n_clr_row  = r_clr_row;
        n_clr_col  = r_clr_col;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = '0;
        w_new_line = 1'b0;

        if (i_cmd.clear_all || i_cmd.clear_row) begin
            w_we    = 1'b1;
            w_waddr = {r_clr_row, r_clr_col};
            w_wdata = {(i_cmd.clear_all ? tcw_pkg::ATTR_RESET : r_attr), tcw_pkg::CH_SPACE};
            if (o_stat.clr_col_last) begin
                n_clr_col = '0;
                if (i_cmd.clear_all) begin
                    n_clr_row = o_stat.clr_row_last ? '0 : r_clr_row + 1'b1;
                end
            end else begin
                n_clr_col = r_clr_col + 1'b1;
            end
        end

        if (i_cmd.exec && (r_kind == tcw_pkg::KIND_PUT)) begin
            case (r_char)
                tcw_pkg::CH_NEWLINE: begin
                    w_new_line = 1'b1;
                end
                tcw_pkg::CH_RETURN: begin
                    n_col = '0;
                end
                tcw_pkg::CH_BACKSPACE: begin
                    if (r_col == '0) begin
                        if (r_row != '0) begin
                            n_row = r_row - 1'b1;
                        end
                    end else begin
                        n_col = r_col - 1'b1;
                    end
                    w_we    = 1'b1;
                    w_waddr = {tcw_pkg::phys_row(r_top, n_row), n_col};
                    w_wdata = {r_attr, tcw_pkg::CH_SPACE};
                end
                default: begin
                    w_we    = 1'b1;
                    w_waddr = {tcw_pkg::phys_row(r_top, r_row), r_col};
                    w_wdata = {r_attr, r_char};
                    if (w_col_end) begin
                        w_new_line = 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            endcase

            // Next line: at the bottom the screen scrolls and the old top row
            // becomes the new bottom row, which the controller then clears.
            if (w_new_line) begin
                n_col = '0;
                if (w_row_end) begin
                    n_top     = (r_top == ROW_LAST) ? '0 : r_top + 1'b1;
                    n_clr_row = r_top;
                    n_clr_col = '0;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_top     <= '0;
            r_attr    <= tcw_pkg::ATTR_RESET;
            r_clr_row <= '0;
            r_clr_col <= '0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_top     <= n_top;
            r_clr_row <= n_clr_row;
            r_clr_col <= n_clr_col;
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
        end
    end

    // Input item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind     <= i_kind;
            r_char     <= i_char_code;
            r_read_row <= i_read_row;
            r_read_col <= i_read_col;
        end
    end

    // Screen store write port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // Screen store read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_kind == tcw_pkg::KIND_READ)) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_col <= r_col;
            r_o_row <= r_row;
            r_o_lin <= w_linear;
            if ((r_kind == tcw_pkg::KIND_READ) && w_in_range) begin
                r_o_char <= r_rd_data[tcw_pkg::CHAR_W-1:0];
                r_o_attr <= r_rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            end else begin
                r_o_char <= '0;
                r_o_attr <= '0;
            end
        end
    end

    assign o_cursor_col    = r_o_col;
    assign o_cursor_row    = r_o_row;
    assign o_cursor_linear = r_o_lin;
    assign o_cell_char     = r_o_char;
    assign o_cell_attr     = r_o_attr;

    // The cursor and the scroll offset always stay on the screen.
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= COL_LAST) && (r_row <= ROW_LAST) && (r_top <= ROW_LAST))
        else $error("cursor or scroll offset left the screen");

    // A scrolling put leaves the cursor at the bottom row start and restarts
    // the row clear.
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_scroll) |=> ((r_row == ROW_LAST) && (r_col == '0) && (r_clr_col == '0)))
        else $error("scroll did not park the cursor at the bottom row start");

endmodule

// ===== design/tcw_ctrl.sv =====
// ============================================================================
// Text console controller
// Sequences the power-up clear, item execution, row clear on scroll and the
// result transfer.
// ============================================================================
module tcw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic               i_kind,
    output tcw_pkg::t_dp_cmd   o_cmd,
    input  tcw_pkg::t_dp_stat  i_stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCROLL,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_in_fire;
    logic   w_out_fire;
    logic   w_out_free;
    logic   w_is_read;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_fire  = r_out_valid && i_out_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // The kind bit is captured with the item; the controller sees it live
    // only in the accept cycle, so keep a copy.
    logic r_is_read;
    assign w_is_read = r_is_read;

    // Commands decoded from the state.
    always_comb begin
        o_cmd           = '0;
        o_cmd.latch     = w_in_fire;
        o_cmd.exec      = (r_state == S_EXEC);
        o_cmd.clear_all = (r_state == S_CLEAR);
        o_cmd.clear_row = (r_state == S_SCROLL);
        o_cmd.load_out  = (r_state == S_DONE) && w_out_free;
    end

    // State and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_is_read   <= 1'b0;
        end else begin
            if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (i_stat.clr_col_last && i_stat.clr_row_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_is_read <= (i_kind == tcw_pkg::KIND_READ);
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (!w_is_read && i_stat.scroll) begin
                        r_state <= S_SCROLL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SCROLL: begin
                    if (i_stat.clr_col_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // An accepted item is executed in the very next cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == S_EXEC))
        else $error("accepted item was not executed next cycle");

    // A result only appears after the result load step.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result valid raised outside the result load step");

endmodule

// ===== design/text_console_writer_unit.sv =====
// ============================================================================
// Text console writer unit
// Character-cell console of 80 by 25 cells with cursor, scrolling and reads.
// ============================================================================
// After reset the unit clears the screen store to blanks with attribute 7,
// one cell per cycle; no item is accepted during that pass, while attribute
// writes are taken at any time. An item then goes from acceptance to a
// waiting result through an accept step, an execute step on the screen
// store and a result load, which waits while the last result is untaken.
// A put that moves past the bottom row scrolls and clears the new bottom
// row through the same store port, one cell a cycle, before its result is
// loaded. The next item is accepted as soon as the result is loaded, even
// while it waits to be taken.
module text_console_writer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_cfg_data,
    tcw_in_if.sink                      i_in,
    tcw_out_if.source                   o_out
);

    tcw_pkg::t_dp_cmd  w_cmd;
    tcw_pkg::t_dp_stat w_stat;

    // Sequencing.
    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_kind      (i_in.kind),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // Cursor, screen store and result register.
    tcw_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_in.kind),
        .i_char_code     (i_in.char_code),
        .i_read_row      (i_in.read_row),
        .i_read_col      (i_in.read_col),
        .o_cursor_col    (o_out.cursor_col),
        .o_cursor_row    (o_out.cursor_row),
        .o_cursor_linear (o_out.cursor_linear),
        .o_cell_char     (o_out.cell_char),
        .o_cell_attr     (o_out.cell_attr)
    );

endmodule

// ===== test/tcw_console_checker.sv =====
// ============================================================================
// Text console result checker
// Watches the item and result channels and the attribute port, keeps its own
// image of the screen and cursor, and compares every result transfer with the
// cursor report predicted for the oldest outstanding item.
// ============================================================================
module tcw_console_checker
    import tcw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CHAR_W-1:0]  i_cfg_data,
    tcw_in_if                  i_in_mon,
    tcw_out_if                 i_out_mon,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_scrolls
);

    localparam int CELL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int REPORT_LIMIT = 10;

    // One result as the block reports it.
    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [LIN_W-1:0]  cursor_linear;
        logic [CHAR_W-1:0] cell_char;
        logic [CHAR_W-1:0] cell_attr;
    } t_cursor_report;

    // Screen image indexed by physical row, attribute in the high byte.
    logic [CELL_W-1:0] screen_img [0:CELL_COUNT-1];
    int unsigned       cur_col;
    int unsigned       cur_row;
    int unsigned       top_row;
    logic [CHAR_W-1:0] text_attr;

    t_cursor_report    expected_reports [$];
    int                fail_total;
    int                checked_total;
    int                scroll_total;

    // Physical cell of a visible row and column.
    function automatic int unsigned cell_index(int unsigned vis_row, int unsigned col);
        return ((top_row + vis_row) % SCREEN_HEIGHT) * SCREEN_WIDTH + col;
    endfunction

    // Start of the next row; at the bottom the screen scrolls and the new
    // bottom row is blanked with the current attribute.
    function automatic void advance_line();
        int unsigned base;
        cur_col = 0;
        if (cur_row + 1 >= SCREEN_HEIGHT) begin
            cur_row = SCREEN_HEIGHT - 1;
            top_row = (top_row + 1) % SCREEN_HEIGHT;
            scroll_total++;
            base = cell_index(cur_row, 0);
            for (int c = 0; c < SCREEN_WIDTH; c++) begin
                screen_img[base + c] = {text_attr, CH_SPACE};
            end
        end else begin
            cur_row++;
        end
    endfunction

    // Applies one accepted item to the screen image and returns its report.
    function automatic t_cursor_report console_step(input logic              kind,
                                                    input logic [CHAR_W-1:0] ch,
                                                    input logic [ROW_W-1:0]  rrow,
                                                    input logic [COL_W-1:0]  rcol);
        t_cursor_report    rep;
        logic [CELL_W-1:0] word;
        rep = '0;
        if (kind == KIND_PUT) begin
            if (ch == CH_NEWLINE) begin
                advance_line();
            end else if (ch == CH_RETURN) begin
                cur_col = 0;
            end else if (ch == CH_BACKSPACE) begin
                // At column 0 the cursor climbs one row, but never above the top.
                if (cur_col == 0) begin
                    if (cur_row > 0) begin
                        cur_row--;
                    end
                end else begin
                    cur_col--;
                end
                screen_img[cell_index(cur_row, cur_col)] = {text_attr, CH_SPACE};
            end else begin
                screen_img[cell_index(cur_row, cur_col)] = {text_attr, ch};
                cur_col++;
                if (cur_col >= SCREEN_WIDTH) begin
                    advance_line();
                end
            end
        end else if (rrow < SCREEN_HEIGHT && rcol < SCREEN_WIDTH) begin
            // Reads outside the screen answer zero.
            word          = screen_img[cell_index(rrow, rcol)];
            rep.cell_char = word[CHAR_W-1:0];
            rep.cell_attr = word[CELL_W-1:CHAR_W];
        end
        rep.cursor_col    = COL_W'(cur_col);
        rep.cursor_row    = ROW_W'(cur_row);
        rep.cursor_linear = LIN_W'(cur_row * SCREEN_WIDTH + cur_col);
        return rep;
    endfunction

    // Predict on each item transfer, compare on each result transfer.
    always @(posedge i_clk) begin
        t_cursor_report want;
        t_cursor_report got;
        if (!i_rst_n) begin
            for (int i = 0; i < CELL_COUNT; i++) begin
                screen_img[i] = {ATTR_RESET, CH_SPACE};
            end
            cur_col   = 0;
            cur_row   = 0;
            top_row   = 0;
            text_attr = ATTR_RESET;
            expected_reports.delete();
            fail_total    = 0;
            checked_total = 0;
            scroll_total  = 0;
        end else begin
            if (i_cfg_we) begin
                text_attr = i_cfg_data;
            end

            if (i_out_mon.valid && i_out_mon.ready) begin
                got.cursor_col    = i_out_mon.cursor_col;
                got.cursor_row    = i_out_mon.cursor_row;
                got.cursor_linear = i_out_mon.cursor_linear;
                got.cell_char     = i_out_mon.cell_char;
                got.cell_attr     = i_out_mon.cell_attr;
                if (expected_reports.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT) begin
                        $display("[%0t] result transfer with no item outstanding", $time);
                    end
                end else begin
                    want = expected_reports.pop_front();
                    checked_total++;
                    if (got.cursor_col !== want.cursor_col
                        || got.cursor_row !== want.cursor_row
                        || got.cursor_linear !== want.cursor_linear
                        || got.cell_char !== want.cell_char
                        || got.cell_attr !== want.cell_attr) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT) begin
                            $display("[%0t] result %0d differs: expected col %0d row %0d lin %0d",
                                     $time, checked_total, want.cursor_col, want.cursor_row,
                                     want.cursor_linear);
                            $display("    char %02h attr %02h, got col %0d row %0d lin %0d",
                                     want.cell_char, want.cell_attr, got.cursor_col,
                                     got.cursor_row, got.cursor_linear);
                            $display("    char %02h attr %02h", got.cell_char, got.cell_attr);
                        end
                    end
                end
            end

            if (i_in_mon.valid && i_in_mon.ready) begin
                expected_reports.push_back(console_step(i_in_mon.kind, i_in_mon.char_code,
                                                        i_in_mon.read_row, i_in_mon.read_col));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_reports.size();
        o_checked    <= checked_total;
        o_scrolls    <= scroll_total;
    end

endmodule

// ===== test/text_console_writer_unit_test.sv =====
// ============================================================================
// Text console writer unit testbench
// Drives put and read items and attribute writes into the console with
// random idling on both channels; a separate checker predicts every cursor
// report and cell read, and this module gives the verdict.
// ============================================================================
module text_console_writer_unit_test;
    import tcw_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    // A scrolling put takes the longest before its result is loaded.
    localparam int DRAIN_CYCLES = 120;
    localparam int DIRECTED_END = 25;
    localparam int PHASE1_END   = DIRECTED_END + 215;
    localparam int PHASE2_END   = DIRECTED_END + 430;
    localparam int PHASE3_END   = DIRECTED_END + 650;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CHAR_W-1:0] cfg_data;

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int cycle_count = 0;
    int fail_count;
    int pending;
    int checked;
    int scrolls;

    tcw_in_if  in_ch ();
    tcw_out_if out_ch ();

    text_console_writer_unit u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    tcw_console_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_scrolls    (scrolls)
    );

    // Clock with a period of two time units.
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Result side stalls at random.
    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Guard against a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("text_console_writer_unit: mismatch");
            $finish;
        end
    end

    // Presents one item after a random gap and returns at its transfer edge.
    // Valid is left high so that a following item keeps it up.
    task automatic send_item(input logic              kind_v,
                             input logic [CHAR_W-1:0] char_v,
                             input logic [ROW_W-1:0]  row_v,
                             input logic [COL_W-1:0]  col_v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind_v;
        in_ch.char_code <= char_v;
        in_ch.read_row  <= row_v;
        in_ch.read_col  <= col_v;
        @(posedge clk);
        while (!in_ch.ready) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Read fields of a put carry random noise.
    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_item(KIND_PUT, ch, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
    endtask

    task automatic read_cell(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
        send_item(KIND_READ, CHAR_W'($urandom_range(0, 255)), r, c);
    endtask

    // Holds off new items until every outstanding result has been taken.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    // Attribute writes happen only with the console idle.
    task automatic set_attribute(input logic [CHAR_W-1:0] attr);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= attr;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // A printable byte, anything but the three control codes.
    function automatic logic [CHAR_W-1:0] random_glyph();
        logic [CHAR_W-1:0] ch;
        do begin
            ch = CHAR_W'($urandom_range(0, 255));
        end while (ch == CH_NEWLINE || ch == CH_BACKSPACE || ch == CH_RETURN);
        return ch;
    endfunction

    // One random sequence: a run of text, line breaks, erasing, reads or noise.
    task automatic run_burst();
        int pick;
        int count;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            // Mostly short words, now and then a line long enough to wrap.
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 12);
            repeat (count) put_char(random_glyph());
        end else if (pick < 48) begin
            repeat ($urandom_range(1, 4)) put_char(CH_NEWLINE);
        end else if (pick < 58) begin
            repeat ($urandom_range(1, 5)) put_char(CH_BACKSPACE);
        end else if (pick < 63) begin
            put_char(CH_RETURN);
        end else if (pick < 88) begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 99) < 15) begin
                    read_cell(ROW_W'($urandom_range(0, 31)),
                              COL_W'($urandom_range(SCREEN_WIDTH, 127)));
                end else begin
                    read_cell(($urandom_range(0, 1) == 0) ? ROW_W'(SCREEN_HEIGHT - 1)
                                  : ROW_W'($urandom_range(0, SCREEN_HEIGHT - 1)),
                              ($urandom_range(0, 1) == 0) ? COL_W'($urandom_range(0, 15))
                                  : COL_W'($urandom_range(0, SCREEN_WIDTH - 1)));
                end
            end
        end else begin
            send_item(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                      ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
        end
    endtask

    // Stimulus and verdict.
    initial begin
        logic [CHAR_W-1:0] last_attr;
        bit                paused;
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_PUT;
        in_ch.char_code = '0;
        in_ch.read_row  = '0;
        in_ch.read_col  = '0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        rst_n           = 1'b0;
        send_idle_pct   = 9;
        recv_idle_pct   = 46;
        items_sent      = 0;
        paused          = 1'b0;
        last_attr       = CHAR_W'($urandom_range(1, 254));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Blank screen after reset, corners and reads outside the screen.
        read_cell(0, 0);
        read_cell(ROW_W'(SCREEN_HEIGHT - 1), COL_W'(SCREEN_WIDTH - 1));
        read_cell(ROW_W'(SCREEN_HEIGHT), 0);
        read_cell(0, COL_W'(SCREEN_WIDTH));
        read_cell(31, 127);
        // Backspace at the home position stays put.
        put_char(CH_BACKSPACE);
        put_char(8'h41);
        put_char(8'hFF);
        put_char(8'h00);
        put_char(8'h80);
        put_char(CH_BACKSPACE);
        put_char(CH_RETURN);
        put_char(8'h48);
        put_char(CH_NEWLINE);
        read_cell(0, 0);
        // Cells already stored keep their attribute after a change.
        set_attribute(8'hA5);
        put_char(8'h42);
        read_cell(0, 1);
        read_cell(1, 0);
        put_char(CH_BACKSPACE);
        // Backspace at column 0 climbs to the row above.
        put_char(CH_BACKSPACE);
        read_cell(0, 0);
        read_cell(1, 0);

        // Sender idles lightly, receiver heavily.
        set_attribute(8'hFF);
        while (items_sent < PHASE1_END) begin
            if (!paused && items_sent >= DIRECTED_END + 100) begin
                wait_drained();
                paused = 1'b1;
            end
            run_burst();
        end

        // Sender idles heavily, receiver lightly.
        set_attribute(8'h00);
        send_idle_pct = 46;
        recv_idle_pct = 9;
        while (items_sent < PHASE2_END) begin
            run_burst();
        end

        // Back to back on both sides.
        set_attribute(last_attr);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (items_sent < PHASE3_END) begin
            run_burst();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d put and read items, %0d results compared, %0d screen scrolls.",
                 items_sent, checked, scrolls);
        $display("Attribute settings 07, a5, ff, 00 and %02h; three idling patterns.",
                 last_attr);
        if (fail_count == 0 && pending == 0) begin
            $display("text_console_writer_unit: match");
        end else begin
            $display("text_console_writer_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tcw_pkg.sv
design/tcw_in_if.sv
design/tcw_out_if.sv
design/tcw_datapath.sv
design/tcw_ctrl.sv
design/text_console_writer_unit.sv
test/tcw_console_checker.sv
test/text_console_writer_unit_test.sv
